[hw/rtl/char_translate_delete_squeeze_defines.svh]
// assertion macros for the character translate, delete and squeeze filter
`ifndef CHAR_TRANSLATE_DELETE_SQUEEZE_DEFINES_SVH
`define CHAR_TRANSLATE_DELETE_SQUEEZE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CTDS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CTDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ctds_pkg.sv]
// shared types and constants of the character translate, delete and squeeze filter
`default_nettype none

package ctds_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 4;
    localparam int MODE_W    = 2;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_TRANSLATE = 2'd0,
        MODE_DELETE    = 2'd1,
        MODE_SQUEEZE   = 2'd2
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FROM_SET   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TO_SET     = 2'd3;

    typedef struct packed {
        logic              emit;
        logic [BYTE_W-1:0] data;
    } result_t;

endpackage

`default_nettype wire

[hw/rtl/ctds_match.sv]
// parallel compare of one byte against the configured set, first match wins
`default_nettype none

module ctds_match #(
    parameter int SET_SIZE = 8
) (
    input  wire logic [ctds_pkg::BYTE_W-1:0]          in_byte,
    input  wire logic [ctds_pkg::LEN_W-1:0]           set_length,
    input  wire logic [SET_SIZE*ctds_pkg::BYTE_W-1:0] from_set,
    output logic                                      hit,
    output logic [SET_SIZE-1:0]                       first_hit
);

    localparam logic [ctds_pkg::LEN_W-1:0] SIZE_LEN = ctds_pkg::LEN_W'(SET_SIZE);

    logic [ctds_pkg::LEN_W-1:0] len_eff;

    assign len_eff = (set_length > SIZE_LEN) ? SIZE_LEN : set_length;

    always_comb
    begin
        hit       = 1'b0;
        first_hit = '0;
        for (int k = SET_SIZE - 1; k >= 0; k--)
        begin
            if ((ctds_pkg::LEN_W'(k) < len_eff) &&
                (from_set[k*ctds_pkg::BYTE_W +: ctds_pkg::BYTE_W] == in_byte))
            begin
                hit       = 1'b1;
                first_hit = '0;
                first_hit[k] = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ctds_filter.sv]
// mode decision: translate, delete or squeeze one byte, or pass it unchanged in the unused mode
`default_nettype none

module ctds_filter #(
    parameter int SET_SIZE = 8
) (
    input  wire logic [ctds_pkg::MODE_W-1:0]          mode,
    input  wire logic [ctds_pkg::BYTE_W-1:0]          in_byte,
    input  wire logic                                 hit,
    input  wire logic [SET_SIZE-1:0]                  first_hit,
    input  wire logic [SET_SIZE*ctds_pkg::BYTE_W-1:0] to_set,
    input  wire logic [ctds_pkg::BYTE_W-1:0]          prev_byte,
    input  wire logic                                 prev_valid,
    output ctds_pkg::result_t                         res
);

    logic [ctds_pkg::BYTE_W-1:0] translated;

    always_comb
    begin
        translated = '0;
        for (int k = 0; k < SET_SIZE; k++)
        begin
            if (first_hit[k])
            begin
                translated = translated | to_set[k*ctds_pkg::BYTE_W +: ctds_pkg::BYTE_W];
            end
        end
    end

    always_comb
    begin
        res.emit = 1'b1;
        res.data = in_byte;
        case (ctds_pkg::mode_t'(mode))
            ctds_pkg::MODE_TRANSLATE:
            begin
                if (hit)
                begin
                    res.data = translated;
                end
            end
            ctds_pkg::MODE_DELETE:
            begin
                res.emit = !hit;
            end
            ctds_pkg::MODE_SQUEEZE:
            begin
                res.emit = !(hit && prev_valid && (prev_byte == in_byte));
            end
            default:
            begin
                res.emit = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/char_translate_delete_squeeze.sv]
// top level of the character translate, delete and squeeze filter
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------
//   in      | in_valid / in_stall  | in_byte
//   out     | out_valid / out_stall| out_byte
//   cfg     | cfg_write_en         | cfg_index, cfg_data
//
// one byte per cycle while no stall holds it; a taken byte goes through the input register to the output register
// the input register and the result register sit around the compare logic
// deleted or squeezed bytes leave the input register without needing the result register
// in_stall is raised only while the input register is full and a stalled result waits
// asynchronous active-low reset clears configuration, history and both valid flags
`default_nettype none

module char_translate_delete_squeeze #(
    parameter int SET_SIZE = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [ctds_pkg::BYTE_W-1:0]      in_byte,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [ctds_pkg::BYTE_W-1:0]           out_byte,
    input  wire logic                             cfg_write_en,
    input  wire logic [ctds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ctds_pkg::CFG_W-1:0]       cfg_data
);

    localparam int SET_W = SET_SIZE * ctds_pkg::BYTE_W;

    logic [ctds_pkg::MODE_W-1:0] mode_reg;
    logic [ctds_pkg::LEN_W-1:0]  set_length_reg;
    logic [SET_W-1:0]            from_set_reg;
    logic [SET_W-1:0]            to_set_reg;

    logic                        s1_valid_reg, s1_valid_next;
    logic [ctds_pkg::BYTE_W-1:0] s1_byte_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [ctds_pkg::BYTE_W-1:0] out_byte_reg;
    logic [ctds_pkg::BYTE_W-1:0] prev_byte_reg;
    logic                        prev_valid_reg;

    logic                        hit;
    logic [SET_SIZE-1:0]         first_hit;
    ctds_pkg::result_t           res;
    logic                        in_accept;
    logic                        out_free;
    logic                        s1_move;

    ctds_match #(
        .SET_SIZE (SET_SIZE)
    ) u_match (
        .in_byte    (s1_byte_reg),
        .set_length (set_length_reg),
        .from_set   (from_set_reg),
        .hit        (hit),
        .first_hit  (first_hit)
    );

    ctds_filter #(
        .SET_SIZE (SET_SIZE)
    ) u_filter (
        .mode       (mode_reg),
        .in_byte    (s1_byte_reg),
        .hit        (hit),
        .first_hit  (first_hit),
        .to_set     (to_set_reg),
        .prev_byte  (prev_byte_reg),
        .prev_valid (prev_valid_reg),
        .res        (res)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_move   = s1_valid_reg && (!res.emit || out_free);
    assign in_stall  = s1_valid_reg && !s1_move;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move && res.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_byte_reg  <= '0;
            prev_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_move)
            begin
                prev_byte_reg  <= s1_byte_reg;
                prev_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= in_byte;
        end
        if (s1_move && res.emit)
        begin
            out_byte_reg <= res.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= '0;
            set_length_reg <= '0;
            from_set_reg   <= '0;
            to_set_reg     <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                ctds_pkg::CFG_MODE:       mode_reg       <= cfg_data[ctds_pkg::MODE_W-1:0];
                ctds_pkg::CFG_SET_LENGTH: set_length_reg <= cfg_data[ctds_pkg::LEN_W-1:0];
                ctds_pkg::CFG_FROM_SET:   from_set_reg   <= cfg_data[SET_W-1:0];
                ctds_pkg::CFG_TO_SET:     to_set_reg     <= cfg_data[SET_W-1:0];
                default:                  mode_reg       <= mode_reg;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

endmodule

`default_nettype wire

[hw/rtl/ctds_checker.sv]
// port-level assertions for the character translate, delete and squeeze filter
`default_nettype none
`include "char_translate_delete_squeeze_defines.svh"

module ctds_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic [ctds_pkg::BYTE_W-1:0] out_byte
);

    `CTDS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte), "stalled output transaction changed")
    `CTDS_ASSERT_IMPLY(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a stalled output")
    `CTDS_ASSERT_IMPLY(a_out_source, $rose(out_valid), $past(in_valid && !in_stall, 2), "output transaction with no input two cycles earlier")
    `CTDS_ASSERT_IMPLY(a_stall_rise, $rose(in_stall), $past(in_valid && !in_stall), "input stall rose without a transaction before it")

endmodule

bind char_translate_delete_squeeze ctds_checker u_ctds_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte)
);

`default_nettype wire

[test/tb_char_translate_delete_squeeze.sv]
// testbench for the character translate, delete and squeeze filter: directed and random byte streams
`default_nettype none

module tb_char_translate_delete_squeeze;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SET_SIZE = 8;
    localparam logic [ctds_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [ctds_pkg::BYTE_W-1:0]    in_byte = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [ctds_pkg::BYTE_W-1:0]    out_byte;
    logic                           cfg_write_en = 1'b0;
    logic [ctds_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ctds_pkg::CFG_W-1:0]     cfg_data = '0;

    // filter settings and history as the block should hold them
    logic [ctds_pkg::MODE_W-1:0]    filt_mode = ctds_pkg::MODE_TRANSLATE;
    logic [ctds_pkg::LEN_W-1:0]     filt_len = '0;
    logic [ctds_pkg::CFG_W-1:0]     filt_from = '0;
    logic [ctds_pkg::CFG_W-1:0]     filt_to = '0;
    logic [ctds_pkg::BYTE_W-1:0]    last_byte = '0;
    logic                           last_seen = 1'b0;

    logic [ctds_pkg::BYTE_W-1:0]    expected_bytes[$];
    logic [ctds_pkg::BYTE_W-1:0]    want_byte;
    int                             send_idle_pct = 0;
    int                             recv_idle_pct = 0;
    int                             failures = 0;
    int                             bytes_sent = 0;
    int                             bytes_returned = 0;
    int                             configs_loaded = 0;

    char_translate_delete_squeeze #(
        .SET_SIZE (SET_SIZE)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // work out what one accepted byte turns into
    task automatic filter_byte(input logic [ctds_pkg::BYTE_W-1:0] b);
        int                          hit;
        int                          lim;
        logic                        emit;
        logic [ctds_pkg::BYTE_W-1:0] res;
        lim = (filt_len > SET_SIZE) ? SET_SIZE : int'(filt_len);
        hit = -1;
        for (int k = 0; k < lim; k++)
        begin
            if (hit < 0 && filt_from[k*8 +: 8] == b)
                hit = k;
        end
        emit = 1'b1;
        res = b;
        case (filt_mode)
            ctds_pkg::MODE_TRANSLATE:
            begin
                if (hit >= 0)
                    res = filt_to[hit*8 +: 8];
            end
            ctds_pkg::MODE_DELETE:
            begin
                if (hit >= 0)
                    emit = 1'b0;
            end
            ctds_pkg::MODE_SQUEEZE:
            begin
                if (hit >= 0 && last_seen && last_byte == b)
                    emit = 1'b0;
            end
            default: ;
        endcase
        last_byte = b;
        last_seen = 1'b1;
        if (emit)
            expected_bytes.push_back(res);
    endtask

    task automatic send_byte(input logic [ctds_pkg::BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        filter_byte(b);
        bytes_sent++;
    endtask

    // stop input and let the pipeline empty
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ctds_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ctds_pkg::CFG_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            ctds_pkg::CFG_MODE:       filt_mode = value[ctds_pkg::MODE_W-1:0];
            ctds_pkg::CFG_SET_LENGTH: filt_len = value[ctds_pkg::LEN_W-1:0];
            ctds_pkg::CFG_FROM_SET:   filt_from = value;
            ctds_pkg::CFG_TO_SET:     filt_to = value;
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [ctds_pkg::MODE_W-1:0] m,
                               input logic [ctds_pkg::LEN_W-1:0] len,
                               input logic [ctds_pkg::CFG_W-1:0] from_chars,
                               input logic [ctds_pkg::CFG_W-1:0] to_chars);
        drain();
        write_reg(ctds_pkg::CFG_MODE, ctds_pkg::CFG_W'(m));
        write_reg(ctds_pkg::CFG_SET_LENGTH, ctds_pkg::CFG_W'(len));
        write_reg(ctds_pkg::CFG_FROM_SET, from_chars);
        write_reg(ctds_pkg::CFG_TO_SET, to_chars);
        cfg_write_en <= 1'b0;
        configs_loaded++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("out_byte unexpected: expected none, actual %02h", out_byte);
                failures++;
            end
            else
            begin
                want_byte = expected_bytes.pop_front();
                if (out_byte !== want_byte)
                begin
                    $error("out_byte mismatch: expected %02h, actual %02h", want_byte, out_byte);
                    failures++;
                end
            end
            bytes_returned++;
        end
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // squeeze must keep the very first byte even though the history byte resets to zero
    task automatic test_first_byte();
        load_config(ctds_pkg::MODE_SQUEEZE, 4'd1, 64'h0, 64'h0);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h01);
    endtask

    task automatic test_empty_set();
        load_config(ctds_pkg::MODE_TRANSLATE, 4'd0, '1, '0);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h5A);
    endtask

    // repeated characters and a zero character in the set
    task automatic test_translate();
        load_config(ctds_pkg::MODE_TRANSLATE, 4'd8, 64'h6564_63FF_6100_6261,
                    64'h1817_1615_1413_1211);
        send_byte(8'h61);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h65);
        send_byte(8'h66);
    endtask

    task automatic test_long_length();
        load_config(ctds_pkg::MODE_TRANSLATE, 4'd15, 64'h6564_63FF_6100_6261,
                    64'h1817_1615_1413_1211);
        send_byte(8'h65);
        send_byte(8'h70);
    endtask

    task automatic test_delete();
        load_config(ctds_pkg::MODE_DELETE, 4'd3, 64'h6564_63FF_6100_6261, '0);
        send_byte(8'h00);
        send_byte(8'h61);
        send_byte(8'h65);
    endtask

    task automatic test_squeeze();
        load_config(ctds_pkg::MODE_SQUEEZE, 4'd2, 64'h0000_0000_0000_6261, '0);
        send_byte(8'h61);
        send_byte(8'h61);
        send_byte(8'h62);
        send_byte(8'h63);
        send_byte(8'h63);
    endtask

    // history carries over a mode change
    task automatic test_mode_history();
        load_config(ctds_pkg::MODE_TRANSLATE, 4'd1, 64'h61, 64'h7A);
        send_byte(8'h61);
        load_config(ctds_pkg::MODE_SQUEEZE, 4'd1, 64'h61, 64'h7A);
        send_byte(8'h61);
    endtask

    task automatic test_unused_mode();
        load_config(MODE_UNUSED, 4'd8, 64'h6564_63FF_6100_6261, 64'h1817_1615_1413_1211);
        send_byte(8'h61);
        send_byte(8'h00);
    endtask

    task automatic load_random_config();
        logic [ctds_pkg::MODE_W-1:0] m;
        logic [ctds_pkg::LEN_W-1:0]  len;
        logic [ctds_pkg::CFG_W-1:0]  from_chars;
        logic [ctds_pkg::CFG_W-1:0]  to_chars;
        int                          r;
        r = $urandom_range(9);
        case (r)
            0, 1, 2: m = ctds_pkg::MODE_TRANSLATE;
            3, 4, 5: m = ctds_pkg::MODE_DELETE;
            9:       m = MODE_UNUSED;
            default: m = ctds_pkg::MODE_SQUEEZE;
        endcase
        r = $urandom_range(9);
        case (r)
            0:       len = 4'd0;
            1:       len = 4'd8;
            2:       len = 4'd15;
            3:       len = ctds_pkg::LEN_W'($urandom_range(9, 15));
            default: len = ctds_pkg::LEN_W'($urandom_range(1, 8));
        endcase
        from_chars = {$urandom, $urandom};
        r = $urandom_range(7);
        if (r == 0)
            from_chars = '0;
        else if (r == 1)
            from_chars = '1;
        else if (r < 4)
            from_chars[$urandom_range(1, 7)*8 +: 8] = from_chars[7:0];
        to_chars = {$urandom, $urandom};
        r = $urandom_range(7);
        if (r == 0)
            to_chars = '0;
        else if (r == 1)
            to_chars = '1;
        load_config(m, len, from_chars, to_chars);
    endtask

    // mostly set characters and runs, some arbitrary bytes
    function automatic logic [ctds_pkg::BYTE_W-1:0] pick_byte(
        input logic [ctds_pkg::BYTE_W-1:0] prev);
        int r;
        r = $urandom_range(9);
        if (r < 3)
            return prev;
        if (r < 7)
            return filt_from[$urandom_range(7)*8 +: 8];
        return ctds_pkg::BYTE_W'($urandom_range(255));
    endfunction

    task automatic test_random_stream(input int count);
        int                          left;
        int                          chunk;
        logic [ctds_pkg::BYTE_W-1:0] b;
        left = count;
        b = '0;
        while (left > 0)
        begin
            load_random_config();
            chunk = $urandom_range(10, 50);
            if (chunk > left)
                chunk = left;
            repeat (chunk)
            begin
                b = pick_byte(b);
                send_byte(b);
            end
            left -= chunk;
        end
    endtask

    initial
    begin
        send_idle_pct = 8;
        recv_idle_pct = 72;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_first_byte();
        test_empty_set();
        test_translate();
        test_long_length();
        test_delete();
        test_squeeze();
        test_mode_history();
        test_unused_mode();
        test_random_stream(310);
        send_idle_pct = 72;
        recv_idle_pct = 8;
        test_random_stream(310);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_stream(310);
        drain();
        repeat (8) @(posedge clk);
        $display("sent %0d bytes over %0d filter settings, %0d bytes came back",
                 bytes_sent, configs_loaded, bytes_returned);
        $display("translate, delete, squeeze and the unused mode with random stalls on both sides");
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
